// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL files. They expand to
// nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// The expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/lpr_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement package
// Fixed widths, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package lpr_pkg;

  localparam int unsigned PAGE_IN_W   = 8;
  localparam int unsigned FRAME_OUT_W = 6;
  localparam int unsigned CFG_W       = 7;
  localparam int unsigned STAMP_W     = 32;
  localparam int unsigned CNT_W       = 32;

  localparam logic [CFG_W-1:0] FRAME_COUNT_RST = 7'd64;

  typedef enum logic [7:0] {
    ST_CLEAR    = 8'b0000_0001,
    ST_IDLE     = 8'b0000_0010,
    ST_LOOK     = 8'b0000_0100,
    ST_SCAN     = 8'b0000_1000,
    ST_SCAN_END = 8'b0001_0000,
    ST_EVICT_RD = 8'b0010_0000,
    ST_EVICT    = 8'b0100_0000,
    ST_FILL     = 8'b1000_0000
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic capture;
    logic do_hit;
    logic do_alloc;
    logic scan_init;
    logic scan_step;
    logic evict_rd;
    logic evict;
    logic fill;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_last;
    logic hit;
    logic has_free;
  } dp_stat_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement
// Timestamp-based least-recently-used page to frame mapper with running
// fault and replacement totals.
// ----------------------------------------------------------------------------
//
// Channel   Signals                                   Transfer
// -------   ---------------------------------------   ------------------------
// request   start, busy, page_number_i                start high, busy low
// config    cfg_valid_i, cfg_ready_o, cfg_data_i      cfg_valid_i & cfg_ready_o
// result    result_valid_o and the six result ports   one-cycle strobe
//
// A hit or a miss served from a free frame keeps busy high only in the lookup
// state and shows its result in the cycle after it. A miss with every frame
// in use walks the valid and stamp table one page per cycle through its
// single read port, then steps through the scan-end, evict-read, evict and
// fill states, with busy high until the result is shown; this walk sets the
// sustained rate. After reset the block clears the valid bits of all
// PAGE_ENTRIES entries, one per cycle, with busy high; configuration writes
// are taken throughout. The result strobe cannot be held off by the receiver,
// and busy falls in the cycle the result is shown, so a new request may be
// taken while it is still on the ports.
//
// Each request carries a page number, reduced modulo PAGE_ENTRIES. A resident
// page is a hit and is stamped with the advanced time. A missing page takes
// the next free frame in order from zero while fewer frames than the
// configured count have been handed out; otherwise the resident page with
// the oldest stamp, lowest page number on a tie, is evicted and its frame is
// reused. The time counter and both totals saturate at their top value.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lru_page_replacement #(
  parameter int unsigned PAGE_ENTRIES = 256,
  parameter int unsigned MAX_FRAMES   = 64
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Request channel.
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [lpr_pkg::PAGE_IN_W-1:0]        page_number_i,
  // Configuration channel: frame count.
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [lpr_pkg::CFG_W-1:0]            cfg_data_i,
  // Result channel.
  output logic                                      result_valid_o,
  output logic                                      was_fault_o,
  output logic                                      was_replacement_o,
  output logic      [lpr_pkg::FRAME_OUT_W-1:0]      frame_number_o,
  output logic      [lpr_pkg::PAGE_IN_W-1:0]        evicted_page_o,
  output logic      [lpr_pkg::CNT_W-1:0]            fault_total_o,
  output logic      [lpr_pkg::CNT_W-1:0]            replacement_total_o
);

  lpr_pkg::dp_cmd_t  cmd;
  lpr_pkg::dp_stat_t stat;
  logic              cfg_we;

  // The frame count register is always ready; the sender must write it only
  // while no request is in flight, which the block itself does not enforce.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  lpr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  lpr_dp #(
    .PAGE_ENTRIES (PAGE_ENTRIES),
    .MAX_FRAMES   (MAX_FRAMES)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .page_number_i       (page_number_i),
    .cfg_we_i            (cfg_we),
    .cfg_data_i          (cfg_data_i),
    .result_valid_o      (result_valid_o),
    .was_fault_o         (was_fault_o),
    .was_replacement_o   (was_replacement_o),
    .frame_number_o      (frame_number_o),
    .evicted_page_o      (evicted_page_o),
    .fault_total_o       (fault_total_o),
    .replacement_total_o (replacement_total_o)
  );

  // A taken request keeps the block busy until its result is shown.
  `ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy, "request taken but not busy")
  // Every request yields a single one-cycle result.
  `ASSERT_NEXT(a_strobe_single, clk_i, rst_ni, result_valid_o, !result_valid_o, "result held two cycles")

endmodule

`default_nettype wire

// ===== hdl/lpr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/lpr_ctrl.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement controller
// Sequences clearing, lookup, the oldest-page scan and the eviction steps.
// ----------------------------------------------------------------------------
`default_nettype none

module lpr_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire lpr_pkg::dp_stat_t stat_i,
  output lpr_pkg::dp_cmd_t       cmd_o,
  output logic                   busy_o
);

  lpr_pkg::ctrl_state_e state_d, state_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      lpr_pkg::ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.cnt_last) begin
          state_d = lpr_pkg::ST_IDLE;
        end
      end
      lpr_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = lpr_pkg::ST_LOOK;
        end
      end
      lpr_pkg::ST_LOOK: begin
        if (stat_i.hit) begin
          cmd_o.do_hit = 1'b1;
          state_d      = lpr_pkg::ST_IDLE;
        end else if (stat_i.has_free) begin
          cmd_o.do_alloc = 1'b1;
          state_d        = lpr_pkg::ST_IDLE;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d         = lpr_pkg::ST_SCAN;
        end
      end
      lpr_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.cnt_last) begin
          state_d = lpr_pkg::ST_SCAN_END;
        end
      end
      lpr_pkg::ST_SCAN_END: begin
        state_d = lpr_pkg::ST_EVICT_RD;
      end
      lpr_pkg::ST_EVICT_RD: begin
        cmd_o.evict_rd = 1'b1;
        state_d        = lpr_pkg::ST_EVICT;
      end
      lpr_pkg::ST_EVICT: begin
        cmd_o.evict = 1'b1;
        state_d     = lpr_pkg::ST_FILL;
      end
      lpr_pkg::ST_FILL: begin
        cmd_o.fill = 1'b1;
        state_d    = lpr_pkg::ST_IDLE;
      end
      default: begin
        state_d = lpr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpr_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lpr_dp.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement datapath
// Page tables in RAM, the time stamp and totals, the oldest-page search and
// the result registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lpr_dp #(
  parameter int unsigned PAGE_ENTRIES = 256,
  parameter int unsigned MAX_FRAMES   = 64
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire lpr_pkg::dp_cmd_t                     cmd_i,
  output lpr_pkg::dp_stat_t                         stat_o,
  input  wire logic [lpr_pkg::PAGE_IN_W-1:0]        page_number_i,
  input  wire logic                                 cfg_we_i,
  input  wire logic [lpr_pkg::CFG_W-1:0]            cfg_data_i,
  output logic                                      result_valid_o,
  output logic                                      was_fault_o,
  output logic                                      was_replacement_o,
  output logic      [lpr_pkg::FRAME_OUT_W-1:0]      frame_number_o,
  output logic      [lpr_pkg::PAGE_IN_W-1:0]        evicted_page_o,
  output logic      [lpr_pkg::CNT_W-1:0]            fault_total_o,
  output logic      [lpr_pkg::CNT_W-1:0]            replacement_total_o
);

  localparam int unsigned PW   = $clog2(PAGE_ENTRIES);
  localparam int unsigned RW   = PW + 1;
  localparam int unsigned FW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned GW   = $clog2(MAX_FRAMES + 1);
  localparam int unsigned CW   = (GW > lpr_pkg::CFG_W) ? GW : lpr_pkg::CFG_W;
  localparam int unsigned SW   = lpr_pkg::STAMP_W;
  localparam int unsigned VSW  = SW + 1;
  localparam int unsigned FOW  = lpr_pkg::FRAME_OUT_W;
  localparam int unsigned PIW  = lpr_pkg::PAGE_IN_W;

  localparam logic [RW-1:0] NP_R      = RW'(PAGE_ENTRIES);
  localparam logic [PW-1:0] LAST_PAGE = PW'(PAGE_ENTRIES - 1);
  localparam logic [CW-1:0] MAXF_C    = CW'(MAX_FRAMES);
  localparam logic [CW-1:0] ONE_C     = CW'(1);

  // Page number modulo PAGE_ENTRIES by restoring reduction, one bit a step.
  function automatic logic [PW-1:0] page_mod(input logic [PIW-1:0] v);
    logic [RW-1:0] r;
    r = '0;
    for (int b = PIW - 1; b >= 0; b--) begin
      r = {r[RW-2:0], v[b]};
      if (r >= NP_R) begin
        r = r - NP_R;
      end
    end
    return r[PW-1:0];
  endfunction

  // Control and counter registers.
  logic [lpr_pkg::CFG_W-1:0] frame_count_q;
  logic [SW-1:0]             time_q, time_d;
  logic [GW-1:0]             given_q;
  logic [lpr_pkg::CNT_W-1:0] fault_cnt_q, repl_cnt_q;
  logic [PW-1:0]             cnt_q;
  logic                      rd_pend_q;
  logic                      found_q;
  logic                      res_valid_q;

  // Payload registers.
  logic [PW-1:0]  page_q;
  logic [PW-1:0]  idx_q;
  logic [PW-1:0]  best_q;
  logic [SW-1:0]  oldest_q;
  logic [FW-1:0]  victim_frame_q;
  logic           out_fault_q;
  logic           out_repl_q;
  logic [FW-1:0]  out_frame_q;
  logic [PW-1:0]  out_evicted_q;

  // RAM ports.
  logic           vs_we, vs_re;
  logic [PW-1:0]  vs_waddr, vs_raddr;
  logic [VSW-1:0] vs_wdata, vs_rdata;
  logic           fr_we, fr_re;
  logic [PW-1:0]  fr_waddr, fr_raddr;
  logic [FW-1:0]  fr_wdata, fr_rdata;

  logic [PW-1:0]  page_in;
  logic [CW-1:0]  eff_frames;
  logic           older;

  assign page_in = page_mod(page_number_i);
  assign time_d  = lpr_pkg::sat_inc(time_q);

  always_comb begin
    if (frame_count_q == '0) begin
      eff_frames = ONE_C;
    end else if (CW'(frame_count_q) > MAXF_C) begin
      eff_frames = MAXF_C;
    end else begin
      eff_frames = CW'(frame_count_q);
    end
  end

  assign stat_o.cnt_last = (cnt_q == LAST_PAGE);
  assign stat_o.hit      = vs_rdata[SW];
  assign stat_o.has_free = (CW'(given_q) < eff_frames);

  // Valid-and-stamp table: cleared after reset, stamped on every access.
  always_comb begin
    vs_we    = 1'b0;
    vs_waddr = page_q;
    vs_wdata = {1'b1, time_d};
    if (cmd_i.clr_step) begin
      vs_we    = 1'b1;
      vs_waddr = cnt_q;
      vs_wdata = '0;
    end else if (cmd_i.evict) begin
      vs_we    = found_q;
      vs_waddr = best_q;
      vs_wdata = '0;
    end else if (cmd_i.do_hit || cmd_i.do_alloc || cmd_i.fill) begin
      vs_we = 1'b1;
    end
  end

  assign vs_re    = cmd_i.capture | cmd_i.scan_step;
  assign vs_raddr = cmd_i.capture ? page_in : cnt_q;

  // Frame table: written only when a page is placed.
  assign fr_we    = cmd_i.do_alloc | cmd_i.fill;
  assign fr_waddr = page_q;
  assign fr_wdata = cmd_i.fill ? victim_frame_q : FW'(given_q);
  assign fr_re    = cmd_i.capture | cmd_i.evict_rd;
  assign fr_raddr = cmd_i.capture ? page_in : best_q;

  lpr_ram #(
    .WIDTH (VSW),
    .DEPTH (PAGE_ENTRIES)
  ) u_vs_ram (
    .clk_i   (clk_i),
    .we_i    (vs_we),
    .waddr_i (vs_waddr),
    .wdata_i (vs_wdata),
    .re_i    (vs_re),
    .raddr_i (vs_raddr),
    .rdata_o (vs_rdata)
  );

  lpr_ram #(
    .WIDTH (FW),
    .DEPTH (PAGE_ENTRIES)
  ) u_fr_ram (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (fr_wdata),
    .re_i    (fr_re),
    .raddr_i (fr_raddr),
    .rdata_o (fr_rdata)
  );

  // A resident page beats the current candidate only with a strictly older
  // stamp, so the lowest page number wins a tie.
  assign older = rd_pend_q && vs_rdata[SW] && (!found_q || (vs_rdata[SW-1:0] < oldest_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= lpr_pkg::FRAME_COUNT_RST;
      time_q        <= '0;
      given_q       <= '0;
      fault_cnt_q   <= '0;
      repl_cnt_q    <= '0;
      cnt_q         <= '0;
      rd_pend_q     <= 1'b0;
      found_q       <= 1'b0;
      res_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        frame_count_q <= cfg_data_i;
      end
      if (cmd_i.do_hit || cmd_i.do_alloc || cmd_i.fill) begin
        time_q <= time_d;
      end
      if (cmd_i.do_alloc) begin
        given_q <= given_q + 1'b1;
      end
      if (cmd_i.do_alloc || cmd_i.fill) begin
        fault_cnt_q <= lpr_pkg::sat_inc(fault_cnt_q);
      end
      if (cmd_i.fill && found_q) begin
        repl_cnt_q <= lpr_pkg::sat_inc(repl_cnt_q);
      end
      if (cmd_i.scan_init) begin
        cnt_q <= '0;
      end else if (cmd_i.clr_step || cmd_i.scan_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      rd_pend_q <= cmd_i.scan_step;
      if (cmd_i.scan_init) begin
        found_q <= 1'b0;
      end else if (older) begin
        found_q <= 1'b1;
      end
      res_valid_q <= cmd_i.do_hit | cmd_i.do_alloc | cmd_i.fill;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      page_q <= page_in;
    end
    if (cmd_i.scan_step) begin
      idx_q <= cnt_q;
    end
    if (older) begin
      best_q   <= idx_q;
      oldest_q <= vs_rdata[SW-1:0];
    end
    if (cmd_i.evict) begin
      victim_frame_q <= found_q ? fr_rdata : '0;
    end
    if (cmd_i.do_hit) begin
      out_fault_q   <= 1'b0;
      out_repl_q    <= 1'b0;
      out_frame_q   <= fr_rdata;
      out_evicted_q <= '0;
    end else if (cmd_i.do_alloc) begin
      out_fault_q   <= 1'b1;
      out_repl_q    <= 1'b0;
      out_frame_q   <= FW'(given_q);
      out_evicted_q <= '0;
    end else if (cmd_i.fill) begin
      out_fault_q   <= 1'b1;
      out_repl_q    <= found_q;
      out_frame_q   <= victim_frame_q;
      out_evicted_q <= found_q ? best_q : '0;
    end
  end

  assign result_valid_o      = res_valid_q;
  assign was_fault_o         = out_fault_q;
  assign was_replacement_o   = out_repl_q;
  assign frame_number_o      = FOW'(out_frame_q);
  assign evicted_page_o      = PIW'(out_evicted_q);
  assign fault_total_o       = fault_cnt_q;
  assign replacement_total_o = repl_cnt_q;

  `ASSERT_ALWAYS(a_given_in_range, clk_i, rst_ni, given_q <= GW'(MAX_FRAMES), "frames given past maximum")
  `ASSERT_IMPL(a_repl_is_fault, clk_i, rst_ni, res_valid_q && out_repl_q, out_fault_q, "replacement without fault")

endmodule

`default_nettype wire

// ===== verif/tb_lru_page_replacement.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU page replacement testbench
// Sends page access requests to lru_page_replacement and predicts every
// result with its own page table model: residency, frame, last-use stamp,
// free-frame allocation and oldest-stamp eviction. A directed part covers the
// page number extremes and the frame count corner settings. Random traffic
// with a moving hot set of pages follows, under three sender idle patterns.
// ----------------------------------------------------------------------------

module tb_lru_page_replacement;

  localparam int unsigned PAGE_COUNT   = 256;
  localparam int unsigned FRAME_LIMIT  = 64;
  // A miss with every frame in use walks the whole table.
  localparam int unsigned SCAN_LATENCY = PAGE_COUNT + 5;
  // The slowest correct run (clearing pass, then nearly every request an
  // eviction with the longest sender gaps) stays below CYCLE_LIMIT.
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned ITEMS_PER_SETTING = 155;

  typedef logic [lpr_pkg::PAGE_IN_W-1:0]   page_t;
  typedef logic [lpr_pkg::FRAME_OUT_W-1:0] frame_t;

  // One result as the block presents it, in port order.
  typedef struct packed {
    logic                      was_fault;
    logic                      was_replacement;
    frame_t                    frame_number;
    page_t                     evicted_page;
    logic [lpr_pkg::CNT_W-1:0] fault_total;
    logic [lpr_pkg::CNT_W-1:0] replacement_total;
  } access_result_t;

  // Clock, reset and block inputs all start at known values.
  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      start         = 1'b0;
  page_t                     page_number_i = '0;
  logic                      cfg_valid_i   = 1'b0;
  logic [lpr_pkg::CFG_W-1:0] cfg_data_i    = '0;

  logic                      busy;
  logic                      cfg_ready_o;
  logic                      result_valid_o;
  logic                      was_fault_o;
  logic                      was_replacement_o;
  frame_t                    frame_number_o;
  page_t                     evicted_page_o;
  logic [lpr_pkg::CNT_W-1:0] fault_total_o;
  logic [lpr_pkg::CNT_W-1:0] replacement_total_o;

  lru_page_replacement #(
    .PAGE_ENTRIES (PAGE_COUNT),
    .MAX_FRAMES   (FRAME_LIMIT)
  ) i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .page_number_i       (page_number_i),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_data_i          (cfg_data_i),
    .result_valid_o      (result_valid_o),
    .was_fault_o         (was_fault_o),
    .was_replacement_o   (was_replacement_o),
    .frame_number_o      (frame_number_o),
    .evicted_page_o      (evicted_page_o),
    .fault_total_o       (fault_total_o),
    .replacement_total_o (replacement_total_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Page table model. It is updated at the clock edge that takes a request,
  // so its state always matches what the block has been asked so far.
  // --------------------------------------------------------------------------
  logic                        resident  [PAGE_COUNT];
  frame_t                      frame_of  [PAGE_COUNT];
  logic [lpr_pkg::STAMP_W-1:0] last_used [PAGE_COUNT];
  logic [lpr_pkg::STAMP_W-1:0] now_stamp;
  logic [lpr_pkg::CFG_W-1:0]   frames_handed;
  logic [lpr_pkg::CNT_W-1:0]   faults_seen;
  logic [lpr_pkg::CNT_W-1:0]   replacements_seen;
  logic [lpr_pkg::CFG_W-1:0]   frame_count_reg;

  access_result_t   expected_results [$];
  int unsigned      fail_count;
  int unsigned      cycle_count;
  int unsigned      sender_idle_pct;
  page_t            hot_base;

  task automatic clear_page_table();
    for (int p = 0; p < PAGE_COUNT; p++) begin
      resident[p]  = 1'b0;
      frame_of[p]  = '0;
      last_used[p] = '0;
    end
    now_stamp         = '0;
    frames_handed     = '0;
    faults_seen       = '0;
    replacements_seen = '0;
    frame_count_reg   = lpr_pkg::FRAME_COUNT_RST;
  endtask

  // A frame count of zero still leaves one frame, and the block never hands
  // out more frames than it was built with.
  function automatic int unsigned frames_allowed_for(
      input logic [lpr_pkg::CFG_W-1:0] count);
    if (count == '0) return 1;
    if (count > FRAME_LIMIT) return FRAME_LIMIT;
    return 32'(count);
  endfunction

  function automatic access_result_t predict_access(input page_t page);
    access_result_t r;
    int             victim;
    r = '0;
    if (resident[page]) begin
      r.frame_number = frame_of[page];
    end else begin
      r.was_fault = 1'b1;
      if (frames_handed < frames_allowed_for(frame_count_reg)) begin
        // Free frames go out in order from zero and are never taken back.
        r.frame_number = frame_t'(frames_handed);
        frames_handed++;
      end else begin
        // Oldest stamp loses its frame; the strict compare keeps the lowest
        // page number on a tie.
        victim = -1;
        for (int p = 0; p < PAGE_COUNT; p++) begin
          if (resident[p] && (victim < 0 || last_used[p] < last_used[victim])) begin
            victim = p;
          end
        end
        if (victim >= 0) begin
          r.frame_number    = frame_of[victim];
          r.evicted_page    = page_t'(victim);
          r.was_replacement = 1'b1;
          resident[victim]  = 1'b0;
          if (replacements_seen != '1) replacements_seen++;
        end
      end
      resident[page] = 1'b1;
      frame_of[page] = r.frame_number;
      if (faults_seen != '1) faults_seen++;
    end
    // Time stops advancing at its top value; later stamps then tie.
    if (now_stamp != '1) now_stamp++;
    last_used[page]     = now_stamp;
    r.fault_total       = faults_seen;
    r.replacement_total = replacements_seen;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking. The strobe lasts one cycle and cannot be held off, so
  // every cycle with it high is a result to compare with the oldest
  // expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    access_result_t seen;
    access_result_t want;
    if (rst_ni && result_valid_o) begin
      seen = {was_fault_o, was_replacement_o, frame_number_o, evicted_page_o,
              fault_total_o, replacement_total_o};
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
          $display("[%0t] result with no request outstanding: fault %0b frame %0d",
                   $realtime, seen.was_fault, seen.frame_number);
        end
      end else begin
        want = expected_results.pop_front();
        if (seen.was_fault !== want.was_fault ||
            seen.was_replacement !== want.was_replacement ||
            seen.frame_number !== want.frame_number ||
            seen.evicted_page !== want.evicted_page ||
            seen.fault_total !== want.fault_total ||
            seen.replacement_total !== want.replacement_total) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("[%0t] result mismatch (expected / actual):", $realtime);
            $display("  fault %0b / %0b  replacement %0b / %0b  frame %0d / %0d",
                     want.was_fault, seen.was_fault, want.was_replacement,
                     seen.was_replacement, want.frame_number, seen.frame_number);
            $display("  evicted %0d / %0d  faults %0d / %0d  replacements %0d / %0d",
                     want.evicted_page, seen.evicted_page, want.fault_total,
                     seen.fault_total, want.replacement_total, seen.replacement_total);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request driving. Start is only raised, never lowered, when a request is
  // taken, so back-to-back requests keep it high; an idle gap lowers it in a
  // step of its own before the next request raises it again.
  // --------------------------------------------------------------------------
  task automatic send_access(input page_t page);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start         <= 1'b1;
    page_number_i <= page;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_results.push_back(predict_access(page));
  endtask

  // Stop sending and wait for every outstanding result. Each request yields
  // exactly one result, so an empty queue means the block is idle.
  task automatic wait_until_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_frame_count(input logic [lpr_pkg::CFG_W-1:0] count);
    wait_until_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= count;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    frame_count_reg = count;
    cfg_valid_i    <= 1'b0;
  endtask

  // Most accesses fall in a small hot window sized after the frame count so
  // that hits, refills and evictions of recently used pages all occur; the
  // window moves now and then, and the rest are uniform over all pages.
  function automatic page_t pick_page(input int unsigned span);
    if ($urandom_range(99) < 3) hot_base = page_t'($urandom_range(255));
    if ($urandom_range(99) < 70) return hot_base + page_t'($urandom_range(span - 1));
    return page_t'($urandom_range(255));
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset frame count of 64: fills from frame 0 with the extreme page
  // numbers and page 128, with hits on pages already resident between.
  task automatic test_reset_frame_count();
    page_t pages [5] = '{8'd0, 8'd255, 8'd0, 8'd128, 8'd255};
    foreach (pages[i]) send_access(pages[i]);
  endtask

  // A frame count of zero acts as one. Three frames are already out, so
  // every miss now evicts the least recently used page.
  task automatic test_frame_count_floor();
    page_t pages [4] = '{8'd17, 8'd17, 8'd200, 8'd0};
    write_frame_count(7'd0);
    foreach (pages[i]) send_access(pages[i]);
  endtask

  // All ones is clamped to the built-in frame limit; free frames resume.
  task automatic test_frame_count_ceiling();
    page_t pages [4] = '{8'd1, 8'd2, 8'd254, 8'd1};
    write_frame_count(7'd127);
    foreach (pages[i]) send_access(pages[i]);
  endtask

  // Lowering the count below the frames already given keeps those frames in
  // use and turns every further miss into a replacement.
  task automatic test_frame_count_lowered();
    page_t pages [5] = '{8'd99, 8'd100, 8'd99, 8'd170, 8'd2};
    write_frame_count(7'd2);
    foreach (pages[i]) send_access(pages[i]);
  endtask

  // Random traffic under one sender idle rate, at two frame count settings.
  // Each setting change waits for the block to drain first.
  task automatic test_random_traffic(input int unsigned idle_pct,
                                     input logic [lpr_pkg::CFG_W-1:0] first_count,
                                     input logic [lpr_pkg::CFG_W-1:0] second_count);
    logic [lpr_pkg::CFG_W-1:0] counts [2];
    int unsigned               span;
    counts[0] = first_count;
    counts[1] = second_count;
    sender_idle_pct = idle_pct;
    foreach (counts[c]) begin
      write_frame_count(counts[c]);
      span = frames_allowed_for(counts[c]);
      span = span + span / 2 + 2;
      repeat (ITEMS_PER_SETTING) send_access(pick_page(span));
    end
  endtask

  initial begin
    clear_page_table();
    fail_count      = 0;
    cycle_count     = 0;
    hot_base        = '0;
    sender_idle_pct = 34;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The first requests wait out the clearing pass that follows reset.
    test_reset_frame_count();
    test_frame_count_floor();
    test_frame_count_ceiling();
    test_frame_count_lowered();

    // Early settings keep few frames in use so that allocation from free
    // frames still happens; the full frame limit is reached in the second.
    test_random_traffic(34, 7'd8, 7'd24);
    test_random_traffic(71, 7'd64, 7'd1);
    test_random_traffic(0, 7'd100, 7'd33);

    wait_until_drained();
    repeat (SCAN_LATENCY) @(posedge clk_i);

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
